/* hdl/acrs_pkg.sv */
`timescale 1ns / 1ps

package acrs_pkg;

    // Internal counter and position widths
    localparam int CNT_W = 16;
    localparam int POS_W = 32;
    localparam int SUM_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 2;

    // Queue between front and back (power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Step codes
    localparam logic [1:0] STEP_MATCH    = 2'd0;
    localparam logic [1:0] STEP_MISMATCH = 2'd1;
    localparam logic [1:0] STEP_INSERT   = 2'd2;
    localparam logic [1:0] STEP_DELETE   = 2'd3;

    // Result codes
    localparam logic [1:0] RES_RUN     = 2'd0;
    localparam logic [1:0] RES_REGION  = 2'd1;
    localparam logic [1:0] RES_SUMMARY = 2'd2;

    // Slots of one task, in emission order
    localparam int SLOT_CLOSE_RUN = 0;
    localparam int SLOT_CLOSE_REG = 1;
    localparam int SLOT_FIN_RUN   = 2;
    localparam int SLOT_FIN_REG   = 3;
    localparam int SLOT_SUMMARY   = 4;
    localparam int N_SLOTS        = 5;

    typedef struct packed {
        logic [1:0] step_kind;
        logic       is_last;
    } t_acrs_step;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] run_length;
        logic [1:0]  run_kind;
        logic [31:0] region_start;
        logic [15:0] region_length;
        logic [15:0] mismatch_total;
        logic [15:0] covered_total;
        logic        last_result;
    } t_acrs_result;

    // Everything one step produces, handed from front to back
    typedef struct packed {
        logic [N_SLOTS-1:0] mask;
        logic [15:0]        close_run_len;
        logic [1:0]         close_run_kind;
        logic [31:0]        close_reg_start;
        logic [15:0]        close_reg_len;
        logic [15:0]        fin_run_len;
        logic [1:0]         fin_run_kind;
        logic [31:0]        fin_reg_start;
        logic [15:0]        fin_reg_len;
        logic [15:0]        mm_total;
        logic [15:0]        cov_total;
    } t_acrs_task;

    function automatic logic [15:0] clip_cnt(input logic [CNT_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [31:0] clip_pos(input logic [POS_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc_cnt(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* hdl/acrs_front.sv */
`timescale 1ns / 1ps

module acrs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  acrs_pkg::t_acrs_step i_in_item,
    output logic                o_in_stall,
    input  logic                i_cfg_valid,
    input  logic [31:0]         i_cfg_data,
    output logic                o_cfg_ready,
    output logic                o_push,
    output acrs_pkg::t_acrs_task o_task,
    input  logic                i_q_full
);
    import acrs_pkg::*;

    logic [31:0]      r_read_start;
    logic [1:0]       r_prev_kind;
    logic [CNT_W-1:0] r_run_count;
    logic [POS_W-1:0] r_region_begin;
    logic [CNT_W-1:0] r_region_size;
    logic             r_region_open;
    logic [CNT_W-1:0] r_mm_count;
    logic [CNT_W-1:0] r_cov_count;

    logic [1:0]       n_prev_kind;
    logic [CNT_W-1:0] n_run_count;
    logic [POS_W-1:0] n_region_begin;
    logic [CNT_W-1:0] n_region_size;
    logic             n_region_open;
    logic [CNT_W-1:0] n_mm_count;
    logic [CNT_W-1:0] n_cov_count;

    logic             accept;
    logic             kind_chg;
    logic [1:0]       kind;
    logic [SUM_W-1:0] begin_sum;
    logic [POS_W-1:0] begin_adv;

    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_full;
    assign kind        = i_in_item.step_kind;
    assign kind_chg    = (kind != r_prev_kind);

    // begin + size + 1, saturating (size is zero whenever no region is open)
    assign begin_sum = SUM_W'(r_region_begin) + SUM_W'(r_region_size) + SUM_W'(1);
    assign begin_adv = (begin_sum > SUM_W'({POS_W{1'b1}})) ? {POS_W{1'b1}}
                                                          : begin_sum[POS_W-1:0];

    always_comb begin
        n_prev_kind    = kind;
        n_run_count    = sat_inc_cnt(kind_chg ? '0 : r_run_count);
        n_region_begin = r_region_begin;
        n_region_size  = r_region_size;
        n_region_open  = r_region_open;
        if (kind == STEP_DELETE) begin
            n_region_begin = begin_adv;
            n_region_size  = '0;
            n_region_open  = 1'b0;
        end else if (kind != STEP_INSERT) begin
            n_region_size = sat_inc_cnt(r_region_size);
            n_region_open = 1'b1;
        end
        n_mm_count  = (kind != STEP_MATCH)  ? sat_inc_cnt(r_mm_count)  : r_mm_count;
        n_cov_count = (kind != STEP_INSERT) ? sat_inc_cnt(r_cov_count) : r_cov_count;

        o_task = '0;
        o_task.mask[SLOT_CLOSE_RUN] = kind_chg && (r_run_count != '0);
        o_task.close_run_len        = clip_cnt(r_run_count);
        o_task.close_run_kind       = r_prev_kind;
        o_task.mask[SLOT_CLOSE_REG] = (kind == STEP_DELETE) && r_region_open;
        o_task.close_reg_start      = clip_pos(r_region_begin);
        o_task.close_reg_len        = clip_cnt(r_region_size);
        o_task.mask[SLOT_FIN_RUN]   = i_in_item.is_last;
        o_task.fin_run_len          = clip_cnt(n_run_count);
        o_task.fin_run_kind         = kind;
        o_task.mask[SLOT_FIN_REG]   = i_in_item.is_last && n_region_open;
        o_task.fin_reg_start        = clip_pos(n_region_begin);
        o_task.fin_reg_len          = clip_cnt(n_region_size);
        o_task.mask[SLOT_SUMMARY]   = i_in_item.is_last;
        o_task.mm_total             = clip_cnt(n_mm_count);
        o_task.cov_total            = clip_cnt(n_cov_count);
    end

    assign o_push = accept && (o_task.mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_start   <= '0;
            r_prev_kind    <= STEP_MATCH;
            r_run_count    <= '0;
            r_region_begin <= '0;
            r_region_size  <= '0;
            r_region_open  <= 1'b0;
            r_mm_count     <= '0;
            r_cov_count    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_read_start <= i_cfg_data;
            end
            if (accept && i_in_item.is_last) begin
                // end of read: back to a clean state
                r_prev_kind    <= STEP_MATCH;
                r_run_count    <= '0;
                r_region_begin <= POS_W'(i_cfg_valid ? i_cfg_data : r_read_start);
                r_region_size  <= '0;
                r_region_open  <= 1'b0;
                r_mm_count     <= '0;
                r_cov_count    <= '0;
            end else if (accept) begin
                r_prev_kind    <= n_prev_kind;
                r_run_count    <= n_run_count;
                r_region_begin <= n_region_begin;
                r_region_size  <= n_region_size;
                r_region_open  <= n_region_open;
                r_mm_count     <= n_mm_count;
                r_cov_count    <= n_cov_count;
            end else if (i_cfg_valid && (r_run_count == '0)) begin
                r_region_begin <= POS_W'(i_cfg_data);
            end
        end
    end

endmodule

/* hdl/acrs_queue.sv */
`timescale 1ns / 1ps

module acrs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  acrs_pkg::t_acrs_task i_task,
    output logic                 o_full,
    input  logic                 i_pop,
    output acrs_pkg::t_acrs_task o_head,
    output logic                 o_empty
);
    import acrs_pkg::*;

    t_acrs_task         r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;
    logic               do_push;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;
    assign do_push = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

/* hdl/acrs_back.sv */
`timescale 1ns / 1ps

module acrs_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  acrs_pkg::t_acrs_task   i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output acrs_pkg::t_acrs_result o_out_item,
    input  logic                   i_out_stall
);
    import acrs_pkg::*;

    logic [N_SLOTS-1:0] r_done;
    logic               r_out_valid;
    t_acrs_result       r_out_item;

    logic [N_SLOTS-1:0] remain;
    logic [N_SLOTS-1:0] pick;
    logic               load;
    logic               emit;
    logic               final_one;
    t_acrs_result       n_out_item;

    assign remain    = i_head.mask & ~r_done;
    assign pick      = remain & (~remain + N_SLOTS'(1));   // lowest pending slot
    assign load      = !r_out_valid || !i_out_stall;
    assign emit      = load && !i_empty;
    assign final_one = ((remain & ~pick) == '0);
    assign o_pop     = emit && final_one;

    always_comb begin
        n_out_item = '0;
        if (pick[SLOT_CLOSE_RUN]) begin
            n_out_item.result_kind = RES_RUN;
            n_out_item.run_length  = i_head.close_run_len;
            n_out_item.run_kind    = i_head.close_run_kind;
        end else if (pick[SLOT_CLOSE_REG]) begin
            n_out_item.result_kind   = RES_REGION;
            n_out_item.region_start  = i_head.close_reg_start;
            n_out_item.region_length = i_head.close_reg_len;
        end else if (pick[SLOT_FIN_RUN]) begin
            n_out_item.result_kind = RES_RUN;
            n_out_item.run_length  = i_head.fin_run_len;
            n_out_item.run_kind    = i_head.fin_run_kind;
        end else if (pick[SLOT_FIN_REG]) begin
            n_out_item.result_kind   = RES_REGION;
            n_out_item.region_start  = i_head.fin_reg_start;
            n_out_item.region_length = i_head.fin_reg_len;
        end else begin
            n_out_item.result_kind    = RES_SUMMARY;
            n_out_item.mismatch_total = i_head.mm_total;
            n_out_item.covered_total  = i_head.cov_total;
        end
        n_out_item.last_result = final_one;
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= !i_empty;
            end
            if (emit) begin
                r_done <= final_one ? '0 : (r_done | pick);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* hdl/alignment_cigar_region_summarizer.sv */
`timescale 1ns / 1ps
// A step's first result reaches o_out_item through the task queue and then the output register.
// Throughput: one step per cycle while the queue is not full; one result per cycle out
// while i_out_stall is low, so a step that yields several results (up to four) holds the
// back end until all are out; the two-entry front/back queue absorbs short bursts.
// Reset (i_rst_n low, synchronous): read_start and all read state cleared, queue empty.

module alignment_cigar_region_summarizer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  acrs_pkg::t_acrs_step   i_in_item,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output acrs_pkg::t_acrs_result o_out_item,
    input  logic                   i_out_stall,
    input  logic                   i_cfg_valid,
    input  logic [31:0]            i_cfg_data,
    output logic                   o_cfg_ready
);
    import acrs_pkg::*;

    // front -> queue
    logic       push;
    t_acrs_task task_in;
    logic       q_full;
    // queue -> back
    t_acrs_task head;
    logic       q_empty;
    logic       pop;

    // Front: run-length state, region tracking and totals; builds one task
    // per step holding every result that step causes (closed run, closed
    // region, and on the final step the open run, open region and summary).
    acrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_push      (push),
        .o_task      (task_in),
        .i_q_full    (q_full)
    );

    // Short task queue: front stalls only when it is full.
    acrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (task_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty)
    );

    // Back: walks the pending slots of the head task in order, one result
    // per cycle into the output register while it is free; flags the task's last result.
    acrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

/* test/tb_alignment_cigar_region_summarizer.sv */
`timescale 1ns / 1ps

module tb_alignment_cigar_region_summarizer;
    import acrs_pkg::*;

    // A step's first result shows up after the task queue and the output register. Cycles
    // to wait before a read_start load so that a step that made no result has left the pipe.
    localparam int SETTLE_CYCLES = 6;
    // Cycles with no handshake on any channel before the run is given up
    localparam int QUIET_LIMIT   = 3000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_acrs_step            i_in_item   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_acrs_result          o_out_item;
    logic                  sink_stall  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [31:0]           i_cfg_data  = '0;
    logic                  o_cfg_ready;

    alignment_cigar_region_summarizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (sink_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow of the read state, kept in step with the block
    // ------------------------------------------------------------------
    logic [31:0]      start_pos;      // read_start register
    logic [1:0]       cigar_kind;     // kind of the open CIGAR run
    logic [CNT_W-1:0] cigar_len;      // length of the open CIGAR run
    logic [POS_W-1:0] ref_base;       // start of the open covered region
    logic [CNT_W-1:0] ref_span;       // bases in the open covered region
    logic             span_open;      // covered bases seen since the last deletion
    logic [CNT_W-1:0] nonmatch_cnt;
    logic [CNT_W-1:0] covered_cnt;

    t_acrs_result step_out[$];          // results of the step just taken
    t_acrs_result expected_results[$];  // in flight, oldest first

    int  fail_count      = 0;
    int  steps_sent      = 0;
    int  results_checked = 0;
    int  start_loads     = 0;
    int  quiet_cycles    = 0;
    // No idling on either side while set
    bit  steady_flow     = 1'b0;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic t_acrs_result cigar_run_item();
        t_acrs_result r;
        r = '0;
        r.result_kind = RES_RUN;
        r.run_length  = 16'(cigar_len);
        r.run_kind    = cigar_kind;
        return r;
    endfunction

    function automatic t_acrs_result covered_item();
        t_acrs_result r;
        r = '0;
        r.result_kind   = RES_REGION;
        r.region_start  = 32'(ref_base);
        r.region_length = 16'(ref_span);
        return r;
    endfunction

    // Back to the state of a fresh read; region start reloads from read_start
    task automatic clear_read();
        cigar_kind   = STEP_MATCH;
        cigar_len    = '0;
        ref_base     = POS_W'(start_pos);
        ref_span     = '0;
        span_open    = 1'b0;
        nonmatch_cnt = '0;
        covered_cnt  = '0;
    endtask

    // Works out the results of one step into step_out and advances the shadow
    task automatic summarize_step(input t_acrs_step s);
        t_acrs_result   r;
        logic [POS_W:0] reach;
        step_out.delete();

        // run-length encoding: a kind change closes the open run
        if (s.step_kind != cigar_kind) begin
            if (cigar_len != '0) begin
                step_out = {step_out, cigar_run_item()};
                cigar_len = '0;
            end
            cigar_kind = s.step_kind;
        end
        cigar_len = count_up(cigar_len);

        // covered regions: deletion closes the region and moves the start one past its end
        // (by one if none is open), insertion leaves the region alone
        if (s.step_kind == STEP_DELETE) begin
            if (span_open) begin
                step_out = {step_out, covered_item()};
                reach    = {1'b0, ref_base} + ref_span;
                ref_base = reach[POS_W] ? '1 : reach[POS_W-1:0];
            end
            ref_base  = (ref_base == '1) ? ref_base : ref_base + 1'b1;
            ref_span  = '0;
            span_open = 1'b0;
        end else if (s.step_kind != STEP_INSERT) begin
            ref_span  = count_up(ref_span);
            span_open = 1'b1;
        end

        if (s.step_kind != STEP_MATCH)
            nonmatch_cnt = count_up(nonmatch_cnt);
        if (s.step_kind != STEP_INSERT)
            covered_cnt = count_up(covered_cnt);

        // end of read: open run, open region, then the summary
        if (s.is_last) begin
            step_out = {step_out, cigar_run_item()};
            if (span_open)
                step_out = {step_out, covered_item()};
            r = '0;
            r.result_kind    = RES_SUMMARY;
            r.mismatch_total = 16'(nonmatch_cnt);
            r.covered_total  = 16'(covered_cnt);
            step_out = {step_out, r};
            clear_read();
        end

        if (step_out.size() != 0) begin
            r = step_out[step_out.size() - 1];
            r.last_result = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sends one step and records what it should produce. When typed is set, the
    // first result of the step is the hand-written one rather than the shadow's.
    // Called at a clock edge; returns at the edge that took the item, valid still high.
    task automatic send_step(input logic [1:0] kind, input logic last,
                             input bit typed, input t_acrs_result typed_first);
        t_acrs_step s;
        int         gap;
        if (!steady_flow && $urandom_range(99) < 14) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        s.step_kind = kind;
        s.is_last   = last;
        i_in_valid <= 1'b1;
        i_in_item  <= s;
        do @(posedge i_clk); while (o_in_stall);
        summarize_step(s);
        if (typed && step_out.size() != 0)
            step_out[0] = typed_first;
        foreach (step_out[k])
            expected_results = {expected_results, step_out[k]};
        steps_sent++;
    endtask

    // Sender goes quiet until every expected result is back, then the pipe settles
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_read_start(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        start_pos = value;
        // region start only follows when no read is under way
        if (cigar_len == '0)
            ref_base = POS_W'(value);
        start_loads++;
    endtask

    // One read with random content; kinds tend to repeat so runs get some length.
    // del_bias raises the share of deletions.
    task automatic random_read(input int steps, input bit finish, input int del_bias);
        logic [1:0] kind;
        kind = 2'($urandom_range(3));
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(99) < del_bias)
                kind = STEP_DELETE;
            else if ($urandom_range(1) == 1)
                kind = 2'($urandom_range(3));
            send_step(kind, finish && (i == steps - 1), 1'b0, '0);
        end
    endtask

    task automatic random_reads(input int budget, input int del_bias);
        int sent;
        int len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
            random_read(len, 1'b1, del_bias);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table. Starts from reset, so read_start is 0.
    // Typed rows give the first result of the step as a CIGAR run.
    // ------------------------------------------------------------------
    typedef struct {
        logic [1:0]  kind;
        logic        last;
        bit          typed;
        int unsigned run_len;
        logic [1:0]  run_kind;
        logic        run_last;
    } t_plan_row;

    t_plan_row directed_plan [20] = '{
        // one-step read: run, region at 0, summary
        '{STEP_MATCH,    1'b1, 1'b1, 1, STEP_MATCH,    1'b0},
        // deletions before any covered base: no region, start moves to 2
        '{STEP_DELETE,   1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_DELETE,   1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_MATCH,    1'b0, 1'b1, 2, STEP_DELETE,   1'b1},
        // insertion inside a region: closes the run only
        '{STEP_INSERT,   1'b0, 1'b1, 1, STEP_MATCH,    1'b1},
        '{STEP_MISMATCH, 1'b0, 1'b1, 1, STEP_INSERT,   1'b1},
        '{STEP_INSERT,   1'b0, 1'b1, 1, STEP_MISMATCH, 1'b1},
        // final deletion: closed run, closed region, open run, summary
        '{STEP_DELETE,   1'b1, 1'b1, 1, STEP_INSERT,   1'b0},
        // read of a lone insertion: no region at all
        '{STEP_INSERT,   1'b1, 1'b1, 1, STEP_INSERT,   1'b0},
        '{STEP_MISMATCH, 1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_MISMATCH, 1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_MISMATCH, 1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_MATCH,    1'b0, 1'b1, 3, STEP_MISMATCH, 1'b1},
        '{STEP_MATCH,    1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_DELETE,   1'b0, 1'b1, 2, STEP_MATCH,    1'b0},
        '{STEP_DELETE,   1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_MISMATCH, 1'b1, 1'b1, 2, STEP_DELETE,   1'b0},
        '{STEP_MATCH,    1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_MATCH,    1'b0, 1'b0, 0, STEP_MATCH,    1'b0},
        '{STEP_MATCH,    1'b1, 1'b1, 3, STEP_MATCH,    1'b0}
    };

    // ------------------------------------------------------------------
    // Result side: random stall, field-by-field compare against the oldest
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_acrs_result want;
        if (!i_rst_n) begin
            sink_stall <= 1'b0;
        end else begin
            if (o_out_valid && !sink_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", o_out_item);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("result_kind", want.result_kind, o_out_item.result_kind);
                    compare_field("run_length", want.run_length, o_out_item.run_length);
                    compare_field("run_kind", want.run_kind, o_out_item.run_kind);
                    compare_field("region_start", want.region_start,
                                  o_out_item.region_start);
                    compare_field("region_length", want.region_length,
                                  o_out_item.region_length);
                    compare_field("mismatch_total", want.mismatch_total,
                                  o_out_item.mismatch_total);
                    compare_field("covered_total", want.covered_total,
                                  o_out_item.covered_total);
                    compare_field("last_result", want.last_result, o_out_item.last_result);
                    results_checked++;
                end
            end
            sink_stall <= !steady_flow && ($urandom_range(99) < 22);
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !sink_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_acrs_result typed;
        start_pos = '0;
        clear_read();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, read_start still at its reset value
        foreach (directed_plan[i]) begin
            typed = '0;
            typed.result_kind = RES_RUN;
            typed.run_length  = 16'(directed_plan[i].run_len);
            typed.run_kind    = directed_plan[i].run_kind;
            typed.last_result = directed_plan[i].run_last;
            send_step(directed_plan[i].kind, directed_plan[i].last,
                      directed_plan[i].typed, typed);
        end
        drain_results();

        // random reads at a random start
        load_read_start($urandom());
        random_reads(20, 10);

        // read_start load in the middle of a read: takes effect on the next read
        random_read(6, 1'b0, 10);
        drain_results();
        load_read_start($urandom());
        random_read(5, 1'b1, 10);

        // stretch with no idling on either side
        steady_flow <= 1'b1;
        random_reads(25, 10);
        steady_flow <= 1'b0;

        // sender holds off until everything is back, then picks up again
        drain_results();
        random_reads(8, 10);
        drain_results();

        // top start position, deletion heavy: position saturation in random reads
        load_read_start(32'hFFFF_FFFF);
        random_reads(18, 40);
        drain_results();

        load_read_start(32'h0000_0000);
        random_reads(12, 10);

        // end: everything back, then a few more cycles for stray results
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d steps, %0d results compared, %0d read_start loads",
                 steps_sent, results_checked, start_loads);
        $display("including position saturation and a load during a read");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
